[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_SLOTS   = 4096;
  localparam int HEADER_SLOTS = 3;
  localparam int FIRST_SLOT   = 2;
  localparam int ADDR_W       = $clog2(HEAP_SLOTS);
  localparam int LEN_W        = ADDR_W + 1;
  localparam int SLACK_W      = 12;
  localparam int STATUS_W     = 2;

  localparam logic [LEN_W-1:0] INIT_LEN =
    LEN_W'(HEAP_SLOTS - FIRST_SLOT - HEADER_SLOTS);

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [LEN_W-1:0]  req_slots;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // one block header entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              used;
    logic [ADDR_W-1:0] link;
  } hdr_t;

  // header store write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_TAIL,
    WR_CUR_SPLIT,
    WR_CUR_WHOLE,
    WR_FREE_MARK,
    WR_MERGE
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic                load_req;
    logic                rd_cur;
    logic                rd_link;
    logic                hold;
    logic                cur_rdata_link;
    logic                cur_hold_link;
    logic                cur_first;
    logic                step_inc;
    wr_sel_t             wr_sel;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_grant;
    logic                out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_type;
    logic addr_bad;
    logic cur_end;
    logic cur_is_hdr;
    logic blk_used;
    logic blk_fits;
    logic do_split;
    logic link_end;
    logic out_busy;
  } stat_t;

endpackage

[rtl/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over a chained heap of block headers.
//
//   channel | signals                  | direction
//   req     | req_valid, req_stall, req | in, one allocate or free
//   rsp     | rsp_valid, rsp_stall, rsp | out, one result per request
//   cfg     | cfg_we, cfg_wdata         | in, split slack register
//
// An allocate walks the chain until a free block fits or the chain ends;
// a free walks the blocks before the freed one, then the merge walk, which
// reads a follower at each step where the current block is free and
// linked on. The single-port header store read sets the pace.
// After reset the first header is initialized before a request is taken.
// A result waiting on rsp_stall holds the controller before return to
// idle; one request is in work at a time.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top import ffha_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [SLACK_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // header store and arithmetic
  ffha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[rtl/ffha_dp.sv]
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header store, walk pointer, step count, split and merge
// arithmetic, configuration register and result register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  req_t          req,
  input  logic          cfg_we,
  input  logic [SLACK_W-1:0] cfg_wdata,
  input  cmd_t          cmd,
  output stat_t         stat,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rsp_t          rsp
);

  hdr_t              mem [HEAP_SLOTS];
  hdr_t              rdata;
  logic [ADDR_W-1:0] cur;
  logic [ADDR_W-1:0] hdr;
  logic [LEN_W-1:0]  want;
  logic [LEN_W-1:0]  steps;
  logic [LEN_W-1:0]  hold_len;
  logic [ADDR_W-1:0] hold_link;
  logic [SLACK_W-1:0] slack;
  logic [ADDR_W-1:0] res_grant;
  logic [STATUS_W-1:0] res_status;

  logic [ADDR_W+1:0] tail_full;
  logic [ADDR_W+1:0] split_thr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  hdr_t              wr_data;
  logic [ADDR_W-1:0] rd_addr;

  // split arithmetic
  assign tail_full = {2'b00, cur} + (ADDR_W+2)'(HEADER_SLOTS) + {1'b0, want};
  assign split_thr = {1'b0, want} + (ADDR_W+2)'(HEADER_SLOTS) + (ADDR_W+2)'(slack);

  // status to controller
  assign stat.req_type   = req.req_type;
  assign stat.addr_bad   = req.free_address < ADDR_W'(FIRST_SLOT + HEADER_SLOTS);
  assign stat.cur_end    = (cur == '0) || (steps == LEN_W'(HEAP_SLOTS));
  assign stat.cur_is_hdr = (cur == hdr);
  assign stat.blk_used   = rdata.used;
  assign stat.blk_fits   = rdata.len >= want;
  assign stat.do_split   = ({1'b0, rdata.len} > split_thr) &&
                           (tail_full[ADDR_W+1:ADDR_W] == 2'b00);
  assign stat.link_end   = (rdata.link == '0);
  assign stat.out_busy   = rsp_valid && rsp_stall;

  // write port source
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur;
    wr_data = rdata;
    case (cmd.wr_sel)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_INIT: begin
        wr_addr = ADDR_W'(FIRST_SLOT);
        wr_data = '{len: INIT_LEN, used: 1'b0, link: '0};
      end
      WR_TAIL: begin
        wr_addr = tail_full[ADDR_W-1:0];
        wr_data = '{len: rdata.len - want - LEN_W'(HEADER_SLOTS), used: 1'b0,
                    link: rdata.link};
      end
      WR_CUR_SPLIT: begin
        wr_data = '{len: want, used: 1'b1, link: tail_full[ADDR_W-1:0]};
      end
      WR_CUR_WHOLE: begin
        wr_data = '{len: rdata.len, used: 1'b1, link: rdata.link};
      end
      WR_FREE_MARK: begin
        wr_data = '{len: rdata.len, used: 1'b0, link: rdata.link};
      end
      WR_MERGE: begin
        wr_data = '{len: hold_len + rdata.len + LEN_W'(HEADER_SLOTS), used: 1'b0,
                    link: rdata.link};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd.rd_link ? rdata.link : cur;

  // header store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_cur || cmd.rd_link) begin
      rdata <= mem[rd_addr];
    end
  end

  // walk and request registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      want  <= req.req_slots;
      hdr   <= req.free_address - ADDR_W'(HEADER_SLOTS);
      cur   <= ADDR_W'(FIRST_SLOT);
      steps <= '0;
    end else if (cmd.cur_first) begin
      cur   <= ADDR_W'(FIRST_SLOT);
      steps <= '0;
    end else begin
      if (cmd.cur_rdata_link) begin
        cur <= rdata.link;
      end else if (cmd.cur_hold_link) begin
        cur <= hold_link;
      end
      if (cmd.step_inc) begin
        steps <= steps + 1'b1;
      end
    end
    if (cmd.hold) begin
      hold_len  <= rdata.len;
      hold_link <= rdata.link;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_grant  <= cmd.res_grant ? cur + ADDR_W'(HEADER_SLOTS) : '0;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slack <= '0;
    end else if (cfg_we) begin
      slack <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.granted_address <= res_grant;
      rsp.status          <= res_status;
    end
  end

endmodule

[rtl/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences the allocate walk, the free lookup and the merge walk.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_WCUR,
    S_F_WALK,
    S_F_NEXT,
    S_F_MARK,
    S_M_RD,
    S_M_CHK,
    S_M_NXT,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    cmd.wr_sel = WR_NONE;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.wr_sel = WR_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (stat.req_type == REQ_ALLOC) begin
            state_next = S_A_RD;
          end else if (stat.addr_bad) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_BAD_FREE;
            state_next   = S_DONE;
          end else begin
            state_next = S_F_WALK;
          end
        end
      end
      S_A_RD: begin
        if (stat.cur_end) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NO_SPACE;
          state_next   = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        cmd.step_inc = 1'b1;
        if (stat.blk_used || !stat.blk_fits) begin
          cmd.cur_rdata_link = 1'b1;
          state_next         = S_A_RD;
        end else if (stat.do_split) begin
          cmd.wr_sel = WR_TAIL;
          state_next = S_A_WCUR;
        end else begin
          cmd.wr_sel    = WR_CUR_WHOLE;
          cmd.res_set   = 1'b1;
          cmd.res_code  = ST_OK;
          cmd.res_grant = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_A_WCUR: begin
        cmd.wr_sel    = WR_CUR_SPLIT;
        cmd.res_set   = 1'b1;
        cmd.res_code  = ST_OK;
        cmd.res_grant = 1'b1;
        state_next    = S_DONE;
      end
      S_F_WALK: begin
        if (stat.cur_is_hdr) begin
          cmd.rd_cur = 1'b1;
          state_next = S_F_MARK;
        end else if (stat.cur_end) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BAD_FREE;
          state_next   = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_F_NEXT;
        end
      end
      S_F_NEXT: begin
        cmd.cur_rdata_link = 1'b1;
        cmd.step_inc       = 1'b1;
        state_next         = S_F_WALK;
      end
      S_F_MARK: begin
        cmd.wr_sel    = WR_FREE_MARK;
        cmd.cur_first = 1'b1;
        state_next    = S_M_RD;
      end
      S_M_RD: begin
        if (stat.cur_end) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_M_CHK;
        end
      end
      S_M_CHK: begin
        cmd.step_inc = 1'b1;
        if (stat.blk_used || stat.link_end) begin
          cmd.cur_rdata_link = 1'b1;
          state_next         = S_M_RD;
        end else begin
          cmd.hold    = 1'b1;
          cmd.rd_link = 1'b1;
          state_next  = S_M_NXT;
        end
      end
      S_M_NXT: begin
        // neighbor in use: move on to it, else absorb it and retry here
        if (stat.blk_used) begin
          cmd.cur_hold_link = 1'b1;
        end else begin
          cmd.wr_sel = WR_MERGE;
        end
        state_next = S_M_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[test/tb_first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Self-checking bench for the first-fit heap allocator. A behavioral copy of
// the header chain predicts each allocate and free result; directed rows
// cover reset state, extremes and error codes, then random traffic runs
// under three idle profiles and several split slack settings.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;
  import ffha_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp;
  logic               cfg_we = 1'b0;
  logic [SLACK_W-1:0] cfg_wdata = '0;

  first_fit_heap_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predicted heap state
  logic [LEN_W-1:0]  heap_len  [HEAP_SLOTS];
  logic              heap_used [HEAP_SLOTS];
  logic [ADDR_W-1:0] heap_link [HEAP_SLOTS];
  logic [SLACK_W-1:0] slack;

  rsp_t pending_rsp [$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   granted_list [$];

  function automatic bit in_heap(int a);
    return a != 0 && a < HEAP_SLOTS;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < HEAP_SLOTS; i++) begin
      heap_len[i] = '0;
      heap_used[i] = 1'b0;
      heap_link[i] = '0;
    end
    heap_len[FIRST_SLOT] = INIT_LEN;
    slack = '0;
  endfunction

  // coalesce each free block with free followers
  function automatic void heap_merge();
    int cur;
    int nxt;
    int steps;
    cur = FIRST_SLOT;
    steps = 0;
    while (in_heap(cur) && steps < HEAP_SLOTS) begin
      nxt = heap_link[cur];
      steps++;
      if (heap_used[cur] || !in_heap(nxt) || heap_used[nxt]) begin
        cur = nxt;
      end else begin
        heap_len[cur] = LEN_W'(heap_len[cur] + heap_len[nxt] + HEADER_SLOTS);
        heap_link[cur] = heap_link[nxt];
      end
    end
  endfunction

  function automatic rsp_t heap_request(req_t r);
    rsp_t res;
    int cur;
    int steps;
    int blen;
    int want;
    int tail;
    int hdr;
    res = '0;
    cur = FIRST_SLOT;
    steps = 0;
    if (r.req_type == REQ_ALLOC) begin
      want = r.req_slots;
      res.status = ST_NO_SPACE;
      while (in_heap(cur) && steps < HEAP_SLOTS) begin
        blen = heap_len[cur];
        steps++;
        if (heap_used[cur] || blen < want) begin
          cur = heap_link[cur];
        end else begin
          if (blen > want + HEADER_SLOTS + slack) begin
            tail = cur + HEADER_SLOTS + want;
            if (tail < HEAP_SLOTS) begin
              heap_len[tail] = LEN_W'(blen - want - HEADER_SLOTS);
              heap_used[tail] = 1'b0;
              heap_link[tail] = heap_link[cur];
              heap_len[cur] = LEN_W'(want);
              heap_link[cur] = ADDR_W'(tail);
            end
          end
          heap_used[cur] = 1'b1;
          res.status = ST_OK;
          res.granted_address = ADDR_W'(cur + HEADER_SLOTS);
          return res;
        end
      end
      return res;
    end
    // free
    if (r.free_address < FIRST_SLOT + HEADER_SLOTS) begin
      res.status = ST_BAD_FREE;
      return res;
    end
    hdr = r.free_address - HEADER_SLOTS;
    while (in_heap(cur) && steps < HEAP_SLOTS && cur != hdr) begin
      cur = heap_link[cur];
      steps++;
    end
    if (cur != hdr) begin
      res.status = ST_BAD_FREE;
      return res;
    end
    heap_used[hdr] = 1'b0;
    heap_merge();
    res.status = ST_OK;
    return res;
  endfunction

  // receiver stall and result check
  always @(posedge clk) begin
    rsp_t want_rsp;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("result with nothing expected: addr %0d status %0d",
                 rsp.granted_address, rsp.status);
          fail_count++;
        end else begin
          want_rsp = pending_rsp.pop_front();
          if (rsp.granted_address !== want_rsp.granted_address) begin
            $error("granted_address expected %0d actual %0d",
                   want_rsp.granted_address, rsp.granted_address);
            fail_count++;
          end
          if (rsp.status !== want_rsp.status) begin
            $error("status expected %0d actual %0d", want_rsp.status, rsp.status);
            fail_count++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // send one request; optional typed expectation is checked against prediction
  // valid drops only when the sender idles or the traffic drains
  task automatic send_req(req_t r, bit has_typed, rsp_t typed);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = heap_request(r);
    if (has_typed && pred !== typed) begin
      $error("table row expected addr %0d status %0d, prediction addr %0d status %0d",
             typed.granted_address, typed.status, pred.granted_address, pred.status);
      fail_count++;
    end
    pending_rsp.push_back(pred);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_slack(logic [SLACK_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slack = v;
  endtask

  function automatic req_t make_req(logic kind, int slots, int faddr);
    req_t r;
    r.req_type = kind;
    r.req_slots = LEN_W'(slots);
    r.free_address = ADDR_W'(faddr);
    return r;
  endfunction

  // directed table
  typedef struct {
    logic kind;
    int   slots;
    int   faddr;
    bit   has_typed;
    logic [ADDR_W-1:0]   typed_addr;
    logic [STATUS_W-1:0] typed_status;
  } row_t;

  row_t rows [] = '{
    '{REQ_FREE,  0,    0,    1, 12'd0, ST_BAD_FREE},
    '{REQ_FREE,  0,    4,    1, 12'd0, ST_BAD_FREE},
    '{REQ_FREE,  0,    5,    1, 12'd0, ST_OK},
    '{REQ_ALLOC, 4096, 0,    1, 12'd0, ST_NO_SPACE},
    '{REQ_ALLOC, 8191, 0,    1, 12'd0, ST_NO_SPACE},
    '{REQ_ALLOC, 0,    4095, 1, 12'd5, ST_OK},
    '{REQ_ALLOC, 10,   0,    1, 12'd8, ST_OK},
    '{REQ_ALLOC, 1,    0,    0, 12'd0, ST_OK},
    '{REQ_FREE,  5000, 8,    1, 12'd0, ST_OK},
    '{REQ_FREE,  0,    8,    1, 12'd0, ST_OK},
    '{REQ_FREE,  0,    9,    1, 12'd0, ST_BAD_FREE},
    '{REQ_FREE,  0,    4095, 1, 12'd0, ST_BAD_FREE},
    '{REQ_ALLOC, 3000, 0,    0, 12'd0, ST_OK},
    '{REQ_ALLOC, 2000, 0,    0, 12'd0, ST_OK},
    '{REQ_FREE,  0,    5,    0, 12'd0, ST_OK},
    '{REQ_FREE,  0,    21,   0, 12'd0, ST_OK},
    '{REQ_ALLOC, 4091, 0,    0, 12'd0, ST_OK},
    '{REQ_FREE,  0,    5,    0, 12'd0, ST_OK},
    '{REQ_ALLOC, 4090, 0,    0, 12'd0, ST_OK},
    '{REQ_FREE,  0,    5,    0, 12'd0, ST_OK}
  };

  // random traffic: half allocates, the rest mostly valid frees of live blocks
  task automatic random_phase(int count);
    req_t r;
    rsp_t dummy;
    int pick;
    int sz;
    dummy = '0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        case ($urandom_range(9))
          0: sz = $urandom_range(8191);
          1: sz = $urandom_range(4096, 1500);
          default: sz = $urandom_range(200);
        endcase
        r = make_req(REQ_ALLOC, sz, $urandom_range(4095));
      end else if (pick < 90 && granted_list.size() != 0) begin
        sz = $urandom_range(granted_list.size() - 1);
        r = make_req(REQ_FREE, $urandom_range(8191), granted_list[sz]);
        granted_list.delete(sz);
      end else begin
        r = make_req(REQ_FREE, $urandom_range(8191), $urandom_range(4095));
      end
      send_req(r, 0, dummy);
      if (r.req_type == REQ_ALLOC && pending_rsp[$].status == ST_OK)
        granted_list.push_back(pending_rsp[$].granted_address);
    end
  endtask

  initial begin
    rsp_t typed;
    heap_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      typed.granted_address = rows[i].typed_addr;
      typed.status = rows[i].typed_status;
      send_req(make_req(rows[i].kind, rows[i].slots, rows[i].faddr),
               rows[i].has_typed, typed);
    end

    // sender waits for every outstanding result
    drain();
    write_slack(12'd4095);
    send_idle_pct = 19;
    recv_idle_pct = 64;
    random_phase(260);

    drain();
    write_slack(12'd0);
    send_idle_pct = 64;
    recv_idle_pct = 19;
    random_phase(260);

    drain();
    write_slack(12'($urandom_range(40)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(140);
    drain();
    write_slack(12'hA5A);
    random_phase(140);

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000000;
    $display("FAILURE");
    $finish;
  end

endmodule
